/* hw/rtl/obbsat_pkg.sv */
// Shared types, constants and small lookup functions for the box overlap tester.
`timescale 1ns / 1ps

package obbsat_pkg;

    localparam int FIELD_W       = 48;
    localparam int NUM_IN_FIELDS = 10;
    localparam int OUT_DATA_W    = 80;

    // Order of the packed input fields in the slave beat.
    localparam int F_A_CENTER = 0;
    localparam int F_A_HALF   = 1;
    localparam int F_A_AXIS   = 2;
    localparam int F_B_CENTER = 5;
    localparam int F_B_HALF   = 6;
    localparam int F_B_AXIS   = 7;

    localparam logic [3:0]  FACE_AXES = 4'd6;
    localparam logic [3:0]  LAST_AXIS = 4'd14;
    localparam logic [23:0] PEN_MAX   = 24'hFFFFFF;
    localparam logic [15:0] THR_RESET = 16'd1;
    localparam logic        REG_THRESHOLD = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AXIS,
        ST_CROSS,
        ST_CROSS_WB,
        ST_SQ,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DOT,
        ST_DOT_WB,
        ST_PROJ,
        ST_PROJ_WB,
        ST_DIST,
        ST_EVAL,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic en;
        logic first;
        logic neg;
    } mac_cmd_t;

    function automatic logic [1:0] rot1(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] rot2(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    // Box A column of a cross-product axis.
    function automatic logic [1:0] cross_a(input logic [3:0] axis);
        case (axis) inside
            4'd6, 4'd7, 4'd8:    return 2'd0;
            4'd9, 4'd10, 4'd11:  return 2'd1;
            4'd12, 4'd13, 4'd14: return 2'd2;
            default:             return 2'd0;
        endcase
    endfunction

    // Box B column of a cross-product axis.
    function automatic logic [1:0] cross_b(input logic [3:0] axis);
        case (axis) inside
            4'd6, 4'd9, 4'd12:  return 2'd0;
            4'd7, 4'd10, 4'd13: return 2'd1;
            4'd8, 4'd11, 4'd14: return 2'd2;
            default:            return 2'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/obbsat_mac.sv */
// Shared signed multiply-accumulate unit.
`timescale 1ns / 1ps

module obbsat_mac import obbsat_pkg::*; #(
    parameter int MW = 19,
    parameter int AW = 40
) (
    input  logic                 aclk,
    input  mac_cmd_t             cmd,
    input  logic signed [MW-1:0] op_a,
    input  logic signed [MW-1:0] op_b,
    output logic signed [AW-1:0] acc
);

    logic signed [2*MW-1:0] prod;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   acc_next;

    always_comb begin
        prod = op_a * op_b;
        term = AW'(prod);
        if (cmd.neg) begin
            term = -term;
        end
        acc_next = (cmd.first ? '0 : acc_reg) + term;
    end

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* hw/rtl/obbsat_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module obbsat_isqrt #(
    parameter int SW = 36
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [SW-1:0]   radicand,
    output logic            busy,
    output logic [SW/2-1:0] root
);

    localparam int LW   = SW / 2;
    localparam int RW   = LW + 3;
    localparam int CNTW = $clog2(LW);
    localparam logic [CNTW-1:0] LAST = CNTW'(LW - 1);

    logic [SW-1:0]   rad_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic [LW-1:0]   root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;

    always_comb begin
        rem_sh = {rem_reg[RW-3:0], rad_reg[SW-1:SW-2]};
        trial  = RW'({root_reg, 2'b01});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[LW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[LW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* hw/rtl/obbsat_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module obbsat_div #(
    parameter int NW = 33,
    parameter int DW = 18,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          busy,
    output logic [QW-1:0] quot
);

    localparam int RW   = DW + 1;
    localparam int CNTW = $clog2(QW);
    localparam logic [CNTW-1:0] LAST = CNTW'(QW - 1);

    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   den_ext;
    logic [DW-1:0]   den_reg;
    logic [QW-1:0]   q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;

    always_comb begin
        rem_sh  = {rem_reg[RW-2:0], q_reg[QW-1]};
        den_ext = RW'(den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The upper numerator part is below the divisor, so QW steps suffice.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= RW'(numer[NW-1:QW]);
            q_reg   <= numer[QW-1:0];
            den_reg <= denom;
        end else if (busy_reg) begin
            if (rem_sh >= den_ext) begin
                rem_reg <= rem_sh - den_ext;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

/* hw/rtl/obb_sat_collision_top.sv */
// Top level of the oriented box overlap tester (separating axis test, 15 axes).
`timescale 1ns / 1ps

// Usage:
//  - Slave stream: one beat carries both boxes (center, half extents and three
//    rotation columns each). s_axis_tready is high only while the block is idle.
//  - Master stream: one beat per pair with hit, penetration and contact normal.
//    The result register holds the beat until m_axis_tready takes it; the
//    block accepts no new pair before that.
//  - APB port: register 0 (byte address 0) is the parallel threshold; write it
//    only while no pair is in flight. pready is tied high.
//  - Sequencing: each tested axis runs in turn on the shared multiply-accumulate
//    unit, root unit and divider, which the sequencer owns. The pair is taken in
//    the idle state and the result presented in the output state. A separating
//    axis ends the test early; a skipped axis stops after its length check. The
//    block works on one pair at a time.
//  - Reset (aresetn low, synchronous): sequencer returns to idle, the output
//    beat is dropped and the threshold goes back to 1.

module obb_sat_collision_top import obbsat_pkg::*; #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_center, a_half_extents, a_axis_x, a_axis_y, a_axis_z, b_center,
    // b_half_extents, b_axis_x, b_axis_y, b_axis_z; 48 bits each, low to high
    input  logic [479:0] s_axis_tdata,
    // Master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit [0], penetration [24:1], contact_normal [72:25], zeros [79:73]
    output logic [79:0]  m_axis_tdata
);

    localparam int CW   = COMPONENT_WIDTH;
    localparam int CW1  = CW + 1;
    localparam int AF   = CW - 2;
    localparam int MW   = CW + 3;
    localparam int VW   = MW;
    localparam int AW   = 2 * MW + 2;
    localparam int SW   = 2 * CW + 4;
    localparam int LW   = CW + 2;
    localparam int DW   = CW + 2;
    localparam int NW   = 2 * CW + 1;
    localparam int FW   = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;
    localparam int PXW  = AW - AF + 24;
    localparam int CMPW = (LW > 16) ? LW : 16;

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (AF - 1);
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};

    state_t state_reg, state_next;

    logic [2:0]  cnt_reg;
    logic [2:0]  sub_reg;
    logic [3:0]  axis_reg;
    logic        found_reg;
    logic [15:0] thr_reg;

    logic signed [CW-1:0]  axa_reg [3][3];
    logic signed [CW-1:0]  axb_reg [3][3];
    logic        [CW-1:0]  h_reg [6];
    logic signed [CW1-1:0] dc_reg [3];
    logic signed [VW-1:0]  v_reg [3];
    logic        [LW-1:0]  len_reg;
    logic signed [CW-1:0]  n_reg [3];
    logic        [DW-1:0]  d_reg [6];
    logic signed [AW-1:0]  proj_reg;
    logic signed [AW-1:0]  best_reg;
    logic signed [CW-1:0]  best_n_reg [3];
    logic                  hit_reg;
    logic [23:0]           pen_reg;
    logic [FIELD_W-1:0]    nrm_reg;

    logic [FW-1:0]         fld_ext [NUM_IN_FIELDS];
    logic signed [CW-1:0]  ca_w [3];
    logic signed [CW-1:0]  cb_w [3];
    logic signed [CW1-1:0] dc_w [3];

    mac_cmd_t              mac_cmd;
    logic signed [MW-1:0]  op_a, op_b;
    logic signed [AW-1:0]  acc;
    logic signed [AW-1:0]  rnd_w;
    logic signed [AW-1:0]  rnd_abs;
    logic signed [AW-1:0]  dist_abs;
    logic signed [AW-1:0]  ov_w;
    logic                  ov_fail;
    logic                  root_start, root_busy;
    logic [LW-1:0]         root_w;
    logic                  div_start, div_busy;
    logic [CW-1:0]         quot_w;
    logic [VW-1:0]         abs_v;
    logic [NW-1:0]         div_num;
    logic                  v_neg;
    logic [CW-1:0]         n_clamp;
    logic                  skip_w;
    logic [1:0]            pair_a, pair_b;
    logic [2:0]            sub_b;
    logic [PXW-1:0]        pen_ext;
    logic [23:0]           pen_sat;
    logic [FW-1:0]         nrm_pack;
    logic                  in_beat, cfg_wr;

    // Box B face axes 3..5 map to B columns 0..2.
    function automatic logic [1:0] pair_face(input logic [3:0] axis);
        logic [3:0] t;
        t = axis - 4'd3;
        return t[1:0];
    endfunction

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, thr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
            thr_reg <= pwdata[15:0];
        end
    end

    // ---------------- input unpacking ----------------
    // Fields narrower than three components are zero-extended before slicing.
    always_comb begin
        for (int f = 0; f < NUM_IN_FIELDS; f++) begin
            fld_ext[f] = FW'(s_axis_tdata[f*FIELD_W +: FIELD_W]);
        end
        for (int k = 0; k < 3; k++) begin
            ca_w[k] = fld_ext[F_A_CENTER][k*CW +: CW];
            cb_w[k] = fld_ext[F_B_CENTER][k*CW +: CW];
            dc_w[k] = CW1'(cb_w[k]) - CW1'(ca_w[k]);
        end
    end

    // ---------------- shared units ----------------
    obbsat_mac #(.MW(MW), .AW(AW)) u_mac (
        .aclk (aclk),
        .cmd  (mac_cmd),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    obbsat_isqrt #(.SW(SW)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc[SW-1:0]),
        .busy     (root_busy),
        .root     (root_w)
    );

    obbsat_div #(.NW(NW), .DW(LW), .QW(CW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (len_reg),
        .busy    (div_busy),
        .quot    (quot_w)
    );

    // ---------------- datapath glue ----------------
    always_comb begin
        pair_a = cross_a(axis_reg);
        pair_b = cross_b(axis_reg);
        sub_b  = sub_reg - 3'd3;

        // Round half up, then magnitude.
        rnd_w   = (acc + HALF) >>> AF;
        rnd_abs = rnd_w[AW-1] ? -rnd_w : rnd_w;

        dist_abs = acc[AW-1] ? -acc : acc;
        ov_w     = proj_reg - dist_abs;
        ov_fail  = ov_w[AW-1] || (ov_w == '0);

        // Normalize: (|v| * 2^AF + len/2) / len, sign restored, clamped.
        v_neg   = v_reg[sub_reg[1:0]][VW-1];
        abs_v   = v_neg ? VW'(-v_reg[sub_reg[1:0]]) : VW'(v_reg[sub_reg[1:0]]);
        div_num = (NW'(abs_v) << AF) + NW'(len_reg >> 1);
        if (!v_neg) begin
            n_clamp = quot_w[CW-1] ? CMAX : quot_w;
        end else begin
            n_clamp = (quot_w > CMIN) ? CMIN : (~quot_w + 1'b1);
        end

        skip_w = (len_reg == '0) ||
                 ((axis_reg >= FACE_AXES) && (CMPW'(len_reg) < CMPW'(thr_reg)));

        pen_ext = PXW'(best_reg[AW-1:AF]);
        pen_sat = (pen_ext > PXW'(PEN_MAX)) ? PEN_MAX : pen_ext[23:0];

        nrm_pack = '0;
        for (int k = 0; k < 3; k++) begin
            nrm_pack[k*CW +: CW] = best_n_reg[k];
        end
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_axis_tvalid) state_next = ST_AXIS;
            ST_AXIS:      state_next = (axis_reg < FACE_AXES) ? ST_SQ : ST_CROSS;
            ST_CROSS:     if (cnt_reg == 3'd1) state_next = ST_CROSS_WB;
            ST_CROSS_WB:  state_next = (sub_reg == 3'd2) ? ST_SQ : ST_CROSS;
            ST_SQ:        if (cnt_reg == 3'd2) state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (!root_busy) state_next = ST_CHECK;
            ST_CHECK:     state_next = skip_w ? ST_NEXT : ST_DIV_GO;
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!div_busy) begin
                    state_next = (sub_reg == 3'd2) ? ST_DOT : ST_DIV_GO;
                end
            end
            ST_DOT:       if (cnt_reg == 3'd2) state_next = ST_DOT_WB;
            ST_DOT_WB:    state_next = (sub_reg == 3'd5) ? ST_PROJ : ST_DOT;
            ST_PROJ:      if (cnt_reg == 3'd5) state_next = ST_PROJ_WB;
            ST_PROJ_WB:   state_next = ST_DIST;
            ST_DIST:      if (cnt_reg == 3'd2) state_next = ST_EVAL;
            ST_EVAL:      state_next = ov_fail ? ST_OUT : ST_NEXT;
            ST_NEXT:      state_next = (axis_reg == LAST_AXIS) ? ST_OUT : ST_AXIS;
            ST_OUT:       if (m_axis_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs to shared units ----------------
    always_comb begin
        mac_cmd       = '0;
        op_a          = '0;
        op_b          = '0;
        root_start    = 1'b0;
        div_start     = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_CROSS: begin
                // Component k: p[k+1]*q[k+2] then minus p[k+2]*q[k+1].
                mac_cmd.en    = 1'b1;
                mac_cmd.first = !cnt_reg[0];
                mac_cmd.neg   = cnt_reg[0];
                op_a = MW'(axa_reg[pair_a][cnt_reg[0] ? rot2(sub_reg[1:0])
                                                      : rot1(sub_reg[1:0])]);
                op_b = MW'(axb_reg[pair_b][cnt_reg[0] ? rot1(sub_reg[1:0])
                                                      : rot2(sub_reg[1:0])]);
            end
            ST_SQ: begin
                mac_cmd.en    = 1'b1;
                mac_cmd.first = (cnt_reg == 3'd0);
                op_a = v_reg[cnt_reg[1:0]];
                op_b = v_reg[cnt_reg[1:0]];
            end
            ST_ROOT_GO: root_start = 1'b1;
            ST_DIV_GO:  div_start  = 1'b1;
            ST_DOT: begin
                mac_cmd.en    = 1'b1;
                mac_cmd.first = (cnt_reg == 3'd0);
                op_a = MW'(n_reg[cnt_reg[1:0]]);
                op_b = (sub_reg < 3'd3) ? MW'(axa_reg[sub_reg[1:0]][cnt_reg[1:0]])
                                        : MW'(axb_reg[sub_b[1:0]][cnt_reg[1:0]]);
            end
            ST_PROJ: begin
                mac_cmd.en    = 1'b1;
                mac_cmd.first = (cnt_reg == 3'd0);
                op_a = MW'(h_reg[cnt_reg]);
                op_b = MW'(d_reg[cnt_reg]);
            end
            ST_DIST: begin
                mac_cmd.en    = 1'b1;
                mac_cmd.first = (cnt_reg == 3'd0);
                op_a = MW'(dc_reg[cnt_reg[1:0]]);
                op_b = MW'(n_reg[cnt_reg[1:0]]);
            end
            ST_OUT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sub_reg   <= '0;
            axis_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        axis_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                end
                ST_CROSS: cnt_reg <= (cnt_reg == 3'd1) ? 3'd0 : cnt_reg + 3'd1;
                ST_SQ, ST_DOT, ST_DIST: begin
                    cnt_reg <= (cnt_reg == 3'd2) ? 3'd0 : cnt_reg + 3'd1;
                end
                ST_PROJ: cnt_reg <= (cnt_reg == 3'd5) ? 3'd0 : cnt_reg + 3'd1;
                ST_CROSS_WB: sub_reg <= (sub_reg == 3'd2) ? 3'd0 : sub_reg + 3'd1;
                ST_DIV_WAIT: begin
                    if (!div_busy) begin
                        sub_reg <= (sub_reg == 3'd2) ? 3'd0 : sub_reg + 3'd1;
                    end
                end
                ST_DOT_WB: sub_reg <= (sub_reg == 3'd5) ? 3'd0 : sub_reg + 3'd1;
                ST_EVAL: begin
                    if (!ov_fail && (!found_reg || ov_w < best_reg)) begin
                        found_reg <= 1'b1;
                    end
                end
                ST_NEXT: begin
                    if (axis_reg != LAST_AXIS) begin
                        axis_reg <= axis_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    for (int i = 0; i < 3; i++) begin
                        for (int k = 0; k < 3; k++) begin
                            axa_reg[i][k] <= fld_ext[F_A_AXIS + i][k*CW +: CW];
                            axb_reg[i][k] <= fld_ext[F_B_AXIS + i][k*CW +: CW];
                        end
                        h_reg[i]     <= fld_ext[F_A_HALF][i*CW +: CW];
                        h_reg[3 + i] <= fld_ext[F_B_HALF][i*CW +: CW];
                        dc_reg[i]    <= dc_w[i];
                    end
                end
            end
            ST_AXIS: begin
                if (axis_reg < FACE_AXES) begin
                    for (int k = 0; k < 3; k++) begin
                        v_reg[k] <= (axis_reg < 4'd3) ? VW'(axa_reg[axis_reg[1:0]][k])
                                                     : VW'(axb_reg[pair_face(axis_reg)][k]);
                    end
                end
            end
            ST_CROSS_WB:  v_reg[sub_reg[1:0]] <= VW'(rnd_w);
            ST_ROOT_WAIT: if (!root_busy) len_reg <= root_w;
            ST_DIV_WAIT:  if (!div_busy) n_reg[sub_reg[1:0]] <= n_clamp;
            ST_DOT_WB:    d_reg[sub_reg] <= DW'(rnd_abs);
            ST_PROJ_WB:   proj_reg <= acc;
            ST_EVAL: begin
                if (ov_fail) begin
                    hit_reg <= 1'b0;
                    pen_reg <= '0;
                    nrm_reg <= '0;
                end else if (!found_reg || ov_w < best_reg) begin
                    best_reg <= ov_w;
                    for (int k = 0; k < 3; k++) begin
                        best_n_reg[k] <= n_reg[k];
                    end
                end
            end
            ST_NEXT: begin
                if (axis_reg == LAST_AXIS) begin
                    hit_reg <= 1'b1;
                    pen_reg <= found_reg ? pen_sat : PEN_MAX;
                    nrm_reg <= found_reg ? nrm_pack[FIELD_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tdata = {7'd0, nrm_reg, pen_reg, hit_reg};

endmodule

/* test/tb.sv */
// Self-checking testbench for the oriented box separating axis overlap tester.
`timescale 1ns / 1ps

module tb import obbsat_pkg::*; ();

    typedef struct {
        logic        hit;
        logic [23:0] depth;
        logic [47:0] normal;
    } contact_t;

    // Scoreboard: predicts the contact result of each accepted box pair and
    // checks the result beats against it in order.
    class contact_scoreboard;
        logic [15:0] threshold;
        contact_t    pending_q[$];
        int          errors;

        function new();
            threshold = THR_RESET;
            errors    = 0;
        endfunction

        function longint comp(logic [479:0] d, int f, int k);
            return longint'($signed(d[f*48 + k*16 +: 16]));
        endfunction

        function longint rnd_shift(longint x);
            return (x + 64'sd8192) >>> 14;
        endfunction

        function longint absl(longint x);
            return x < 0 ? -x : x;
        endfunction

        function longint root_floor(longint s);
            longint r, b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function contact_t predict(logic [479:0] d);
            longint ax[15][3];
            longint ha[3], hb[3], dc[3], n[3], bn[3];
            longint s, len, q, proj, dsum, ov, best, dp, thr2;
            bit found;
            contact_t c;
            found = 0;
            best  = 0;
            bn    = '{0, 0, 0};
            thr2  = longint'(threshold) * longint'(threshold);
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    ax[i][k]     = comp(d, F_A_AXIS + i, k);
                    ax[3 + i][k] = comp(d, F_B_AXIS + i, k);
                end
                ha[k] = longint'(d[F_A_HALF*48 + k*16 +: 16]);
                hb[k] = longint'(d[F_B_HALF*48 + k*16 +: 16]);
                dc[k] = comp(d, F_B_CENTER, k) - comp(d, F_A_CENTER, k);
            end
            // cross axes A[i] x B[j] land at 6 + 3i + j
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    ax[6+3*i+j][0] = rnd_shift(ax[i][1]*ax[3+j][2] - ax[i][2]*ax[3+j][1]);
                    ax[6+3*i+j][1] = rnd_shift(ax[i][2]*ax[3+j][0] - ax[i][0]*ax[3+j][2]);
                    ax[6+3*i+j][2] = rnd_shift(ax[i][0]*ax[3+j][1] - ax[i][1]*ax[3+j][0]);
                end
            for (int i = 0; i < 15; i++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += ax[i][k] * ax[i][k];
                if (s == 0 || (i >= 6 && s < thr2)) continue;
                len = root_floor(s);
                for (int k = 0; k < 3; k++) begin
                    q = (absl(ax[i][k]) * 16384 + len / 2) / len;
                    if (ax[i][k] < 0) q = -q;
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                    n[k] = q;
                end
                proj = 0;
                for (int j = 0; j < 6; j++) begin
                    dp = 0;
                    for (int k = 0; k < 3; k++) dp += n[k] * ax[j][k];
                    dp = absl(rnd_shift(dp));
                    proj += (j < 3 ? ha[j] : hb[j-3]) * dp;
                end
                dsum = 0;
                for (int k = 0; k < 3; k++) dsum += dc[k] * n[k];
                ov = proj - absl(dsum);
                if (ov <= 0) begin
                    c.hit = 0; c.depth = '0; c.normal = '0;
                    return c;
                end
                if (!found || ov < best) begin
                    found = 1;
                    best  = ov;
                    bn    = n;
                end
            end
            c.hit = 1;
            if (found) begin
                best    = best >>> 14;
                c.depth = best > 64'sh0FFFFFF ? PEN_MAX : best[23:0];
                c.normal = {bn[2][15:0], bn[1][15:0], bn[0][15:0]};
            end else begin
                c.depth  = PEN_MAX;
                c.normal = '0;
            end
            return c;
        endfunction

        function void note_pair(logic [479:0] d);
            pending_q.push_back(predict(d));
        endfunction

        function void check_result(logic [79:0] t);
            contact_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", t);
                return;
            end
            e = pending_q.pop_front();
            if (t[0] !== e.hit || t[24:1] !== e.depth || t[72:25] !== e.normal
                || t[79:73] !== 7'd0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp hit %b depth %h normal %h, got %h",
                             e.hit, e.depth, e.normal, t);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn;
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata, prdata;
    logic         pready;
    logic         s_axis_tvalid, s_axis_tready;
    logic [479:0] s_axis_tdata;   // ten 48-bit fields, a_center lowest
    logic         m_axis_tvalid, m_axis_tready;
    logic [79:0]  m_axis_tdata;   // hit, penetration, contact_normal, zeros

    contact_scoreboard sb = new();
    int snd_idle, rcv_idle, n_results;
    bit held_off;

    obb_sat_collision_top dut (.*);

    // 10 ns clock
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Note every accepted pair; check every result beat and pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) sb.note_pair(s_axis_tdata);
    end

    initial begin
        m_axis_tready = 0;
        n_results     = 0;
        held_off      = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                n_results++;
            end
            if (n_results == 30 && !held_off) begin
                // long hold-off: the block stalls its input behind the held beat
                held_off = 1;
                m_axis_tready <= 0;
                repeat (3000) @(posedge aclk);
            end
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic write_threshold(logic [15:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= {16'd0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.threshold = v;
    endtask

    // Leaves tvalid high after the beat; the next call or the caller drops it.
    task automatic send_pair(logic [479:0] d);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    function automatic logic [47:0] v3(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [479:0] pair(logic [47:0] ac, ah, ax, ay, az,
                                          logic [47:0] bc, bh, bx, by, bz);
        return {bz, by, bx, bh, bc, az, ay, ax, ah, ac};
    endfunction

    // Mostly plausible rotations and nearby centers; the rest raw noise.
    function automatic logic [479:0] random_pair();
        logic [47:0] f[10];
        int p;
        if ($urandom_range(99) < 20) begin
            for (int i = 0; i < 10; i++) f[i] = {$urandom(), $urandom()};
        end else begin
            for (int b = 0; b < 2; b++) begin
                f[5*b]     = v3($urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
                                $urandom_range(2048) - 1024);
                f[5*b + 1] = v3($urandom_range(768, 32), $urandom_range(768, 32),
                                $urandom_range(768, 32));
                p = $urandom_range(3);
                if (p == 0) begin
                    f[5*b+2] = v3(11585, 11585, 0);
                    f[5*b+3] = v3(-11585, 11585, 0);
                    f[5*b+4] = v3(0, 0, 16384);
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        int c[3];
                        c = '{$urandom_range(400) - 200, $urandom_range(400) - 200,
                              $urandom_range(400) - 200};
                        c[(i + p) % 3] = $urandom_range(1) ? 16384 : -16384;
                        f[5*b + 2 + i] = v3(c[0], c[1], c[2]);
                    end
                end
            end
        end
        return pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]);
    endfunction

    initial begin
        logic [47:0] ex, ey, ez, one, zero;
        logic [15:0] thr_set[4];
        int total;
        aresetn = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        snd_idle = 33; rcv_idle = 56;
        total = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        ex = v3(16384, 0, 0); ey = v3(0, 16384, 0); ez = v3(0, 0, 16384);
        one = v3(256, 256, 256); zero = '0;
        // directed: nothing to test, aligned overlap, separation, tie, extremes
        send_pair('0);
        send_pair(pair(zero, one, ex, ey, ez, v3(256, 0, 0), one, ex, ey, ez));
        send_pair(pair(zero, one, ex, ey, ez, v3(1024, 0, 0), one, ex, ey, ez));
        send_pair(pair(zero, one, ex, ey, ez, v3(511, 0, 0), one, ex, ey, ez));
        send_pair(pair(zero, one, ex, ey, ez, v3(512, 0, 0), one, ex, ey, ez));
        send_pair(pair(zero, one, ex, ey, ez, zero, one, ex, ey, ez));
        send_pair(pair(zero, one, ex, ey, ez, v3(100, 100, 0), one,
                       v3(11585, 11585, 0), v3(-11585, 11585, 0), ez));
        send_pair(pair(v3(-32768, -32768, -32768), v3(65535, 65535, 65535), ex, ey, ez,
                       v3(32767, 32767, 32767), v3(65535, 65535, 65535), ex, ey, ez));
        send_pair(pair(zero, v3(65535, 65535, 65535), v3(32767, 32767, 32767),
                       v3(-32768, -32768, -32768), v3(32767, -32768, 32767),
                       zero, v3(65535, 65535, 65535), v3(-32768, 32767, -32768),
                       v3(32767, 32767, -32768), v3(-32768, 32767, 32767)));
        send_pair({480{1'b1}});
        send_pair(pair(zero, zero, ex, ey, ez, zero, zero, ex, ey, ez));
        send_pair(pair(zero, one, zero, zero, zero, v3(10, 0, 0), one, ex, zero, zero));
        s_axis_tvalid <= 0;
        @(posedge aclk);
        total = 12;

        thr_set = '{16'd0, 16'd65535, 16'($urandom_range(20000, 2)), 16'd1};
        for (int ph = 0; ph < 4; ph++) begin
            wait (sb.pending_q.size() == 0);
            repeat (20) @(posedge aclk);
            write_threshold(thr_set[ph]);
            for (int i = 0; i < 135; i++) begin
                if (total == 190) begin snd_idle = 56; rcv_idle = 33; end
                if (total == 370) begin snd_idle = 0;  rcv_idle = 0;  end
                send_pair(random_pair());
                total++;
            end
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end

        wait (sb.pending_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #300ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/obbsat_pkg.sv
hw/rtl/obbsat_mac.sv
hw/rtl/obbsat_isqrt.sv
hw/rtl/obbsat_div.sv
hw/rtl/obb_sat_collision_top.sv
test/tb.sv
